/* rtl/fgbe_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the font glyph bit expander
// used by fgbe_ctrl, fgbe_datapath and font_glyph_bit_expander_unit
package fgbe_pkg;

	localparam logic CMD_HEADER = 1'b0;
	localparam logic CMD_BITMAP = 1'b1;

	localparam logic KIND_PIXEL   = 1'b0;
	localparam logic KIND_ADVANCE = 1'b1;

	localparam logic [1:0] MODE_BAR   = 2'd0;
	localparam logic [1:0] MODE_MERGE = 2'd1;

	localparam logic [1:0] REG_FG_COLOR  = 2'd0;
	localparam logic [1:0] REG_BG_COLOR  = 2'd1;
	localparam logic [1:0] REG_DRAW_MODE = 2'd2;

	localparam logic [15:0] FG_COLOR_RESET = 16'hFFFF;
	localparam logic [15:0] BG_COLOR_RESET = 16'h0000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BITS,
		ST_FLUSH
	} fgbe_state_t;

	typedef struct packed {
		logic hdr_load;
		logic byte_load;
		logic bit_step;
		logic flush_out;
	} fgbe_cmd_t;

	typedef struct packed {
		logic out_free;
		logic pend_valid;
		logic bits_done;
	} fgbe_status_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] color;
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  advance;
		logic        glyph_end;
	} fgbe_result_t;

	function automatic logic [15:0] swap16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

endpackage

/* rtl/fgbe_ctrl.sv */
`timescale 1ns / 1ps
// controller state machine of the font glyph bit expander
// depends on fgbe_pkg; drives fgbe_datapath through command and status structs
module fgbe_ctrl
	import fgbe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         cmd,
	output logic         in_ready,
	input  fgbe_status_t status,
	output fgbe_cmd_t    ctl
);

	fgbe_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (cmd == CMD_BITMAP) ? ST_BITS : ST_FLUSH;
				end
			end
			ST_BITS: begin
				if (status.bits_done) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!status.pend_valid || status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		ctl.hdr_load  = 1'b0;
		ctl.byte_load = 1'b0;
		ctl.bit_step  = 1'b0;
		ctl.flush_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				ctl.hdr_load  = in_valid && (cmd == CMD_HEADER);
				ctl.byte_load = in_valid && (cmd == CMD_BITMAP);
			end
			ST_BITS: begin
				ctl.bit_step = !status.bits_done &&
					(status.out_free || !status.pend_valid);
			end
			ST_FLUSH: begin
				ctl.flush_out = status.pend_valid && status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/fgbe_datapath.sv */
`timescale 1ns / 1ps
// datapath of the font glyph bit expander: config, glyph box state,
// bit shifter, pending result and output register; depends on fgbe_pkg
module fgbe_datapath
	import fgbe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_write,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic [7:0]   glyph_width,
	input  logic [7:0]   glyph_height,
	input  logic signed [7:0] x_offset,
	input  logic signed [7:0] y_offset,
	input  logic [7:0]   x_advance,
	input  logic [15:0]  pen_x,
	input  logic [15:0]  pen_y,
	input  logic [7:0]   bitmap_byte,
	input  fgbe_cmd_t    ctl,
	output fgbe_status_t status,
	input  logic         out_ready,
	output logic         out_valid,
	output fgbe_result_t out_res,
	output logic         out_last
);

	logic [15:0] fg_color_q, bg_color_q;
	logic [1:0]  draw_mode_q;

	logic [15:0] box_x_q, box_y_q;
	logic [7:0]  box_width_q, box_height_q;
	logic [7:0]  column_count_q, row_count_q;
	logic        glyph_active_q;

	logic [7:0]  byte_q;
	logic [3:0]  bit_idx_q;

	fgbe_result_t pend_q;
	logic         pend_valid_q;
	fgbe_result_t out_q;
	logic         out_last_q;
	logic         out_valid_q;

	logic         out_free;
	logic         bit_set;
	logic [7:0]   col_next, row_next;
	logic         col_wrap, glyph_done;
	logic         emit;
	fgbe_result_t pix_res, hdr_res;
	logic         out_load;

	assign out_free = !out_valid_q || out_ready;

	assign status.out_free   = out_free;
	assign status.pend_valid = pend_valid_q;
	assign status.bits_done  = bit_idx_q[3] || !glyph_active_q;

	// one glyph bit per step
	assign bit_set    = byte_q[7];
	assign col_next   = column_count_q + 8'd1;
	assign col_wrap   = col_next >= box_width_q;
	assign row_next   = row_count_q + 8'd1;
	assign glyph_done = col_wrap && (row_next >= box_height_q);
	assign emit       = (draw_mode_q == MODE_BAR) || ((draw_mode_q == MODE_MERGE) && bit_set);

	always_comb begin
		pix_res.kind      = KIND_PIXEL;
		pix_res.color     = (draw_mode_q == MODE_BAR && !bit_set) ?
			swap16(bg_color_q) : swap16(fg_color_q);
		pix_res.x         = box_x_q + {8'd0, column_count_q};
		pix_res.y         = box_y_q + {8'd0, row_count_q};
		pix_res.advance   = 8'd0;
		pix_res.glyph_end = glyph_done;

		hdr_res.kind      = KIND_ADVANCE;
		hdr_res.color     = 16'd0;
		hdr_res.x         = 16'd0;
		hdr_res.y         = 16'd0;
		hdr_res.advance   = (glyph_width == 8'd0) ? x_advance :
			(8'(x_offset) + glyph_width);
		hdr_res.glyph_end = 1'b0;
	end

	assign out_load = ctl.flush_out || (ctl.bit_step && emit && pend_valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_color_q     <= FG_COLOR_RESET;
			bg_color_q     <= BG_COLOR_RESET;
			draw_mode_q    <= MODE_BAR;
			box_x_q        <= 16'd0;
			box_y_q        <= 16'd0;
			box_width_q    <= 8'd0;
			box_height_q   <= 8'd0;
			column_count_q <= 8'd0;
			row_count_q    <= 8'd0;
			glyph_active_q <= 1'b0;
			bit_idx_q      <= 4'd0;
			pend_valid_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_FG_COLOR:  fg_color_q  <= cfg_data;
					REG_BG_COLOR:  bg_color_q  <= cfg_data;
					REG_DRAW_MODE: draw_mode_q <= cfg_data[1:0];
					default: begin
					end
				endcase
			end

			if (ctl.hdr_load) begin
				box_x_q        <= pen_x + 16'(signed'(x_offset));
				box_y_q        <= pen_y + 16'(signed'(y_offset));
				box_width_q    <= glyph_width;
				box_height_q   <= glyph_height;
				column_count_q <= 8'd0;
				row_count_q    <= 8'd0;
				glyph_active_q <= (glyph_width != 8'd0) && (glyph_height != 8'd0);
				pend_valid_q   <= 1'b1;
			end

			if (ctl.byte_load) begin
				bit_idx_q <= 4'd0;
			end

			if (ctl.bit_step) begin
				bit_idx_q <= bit_idx_q + 4'd1;
				if (col_wrap) begin
					column_count_q <= 8'd0;
					row_count_q    <= row_next;
					if (glyph_done) begin
						glyph_active_q <= 1'b0;
					end
				end else begin
					column_count_q <= col_next;
				end
				if (emit) begin
					pend_valid_q <= 1'b1;
				end
			end

			if (ctl.flush_out) begin
				pend_valid_q <= 1'b0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.byte_load) begin
			byte_q <= bitmap_byte;
		end else if (ctl.bit_step) begin
			byte_q <= {byte_q[6:0], 1'b0};
		end

		if (ctl.hdr_load) begin
			pend_q <= hdr_res;
		end else if (ctl.bit_step && emit) begin
			pend_q <= pix_res;
		end

		if (out_load) begin
			out_q      <= pend_q;
			out_last_q <= ctl.flush_out;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

endmodule

/* rtl/font_glyph_bit_expander_unit.sv */
`timescale 1ns / 1ps
// top level of the font glyph bit expander
// depends on fgbe_pkg, fgbe_ctrl and fgbe_datapath
//
// A header request (cmd 0) opens a glyph box and answers with one pen advance
// result; each bitmap request (cmd 1) expands up to eight glyph bits, msb first,
// into pixel results by draw mode (bar, merge or none). One request is handled
// at a time. A bitmap byte is consumed one glyph bit per step (at most 8) by the
// single bit-step datapath, which stalls while a held result cannot move on; one
// result is held back so the last result of a request can be flagged, and the
// output register lets the next request be taken while a result waits.
// Configuration writes are always ready and must only happen while idle.
module font_glyph_bit_expander_unit
	import fgbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  glyph_width,
	input  logic [7:0]  glyph_height,
	input  logic signed [7:0] x_offset,
	input  logic signed [7:0] y_offset,
	input  logic [7:0]  x_advance,
	input  logic [15:0] pen_x,
	input  logic [15:0] pen_y,
	input  logic [7:0]  bitmap_byte,

	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [15:0] pixel_color,
	output logic [15:0] pixel_x,
	output logic [15:0] pixel_y,
	output logic [7:0]  advance,
	output logic        glyph_end,
	output logic        last
);

	fgbe_cmd_t    ctl;
	fgbe_status_t status;
	fgbe_result_t res;

	assign cfg_ready = 1'b1;

	fgbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_ready (in_ready),
		.status   (status),
		.ctl      (ctl)
	);

	fgbe_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.glyph_width  (glyph_width),
		.glyph_height (glyph_height),
		.x_offset     (x_offset),
		.y_offset     (y_offset),
		.x_advance    (x_advance),
		.pen_x        (pen_x),
		.pen_y        (pen_y),
		.bitmap_byte  (bitmap_byte),
		.ctl          (ctl),
		.status       (status),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.out_res      (res),
		.out_last     (last)
	);

	assign kind        = res.kind;
	assign pixel_color = res.color;
	assign pixel_x     = res.x;
	assign pixel_y     = res.y;
	assign advance     = res.advance;
	assign glyph_end   = res.glyph_end;

endmodule
